// ===== src/ecm_pkg.sv =====
// ============================================================================
// ecm_pkg - shared constants and types for the edge coverage counter map
// Slot layout, hash constants, item kind codes and the hash unit handshake.
// ============================================================================
package ecm_pkg;

    // Slot layout: edge counters first, request counters just above them.
    // Both region sizes are powers of two so that the slot pick is a mask.
    localparam int EDGE_SLOTS  = 131072;
    localparam int REQ_SLOTS   = 256;
    localparam int TOTAL_SLOTS = EDGE_SLOTS + REQ_SLOTS;
    localparam int EDGE_AW     = $clog2(EDGE_SLOTS);
    localparam int REQ_AW      = $clog2(REQ_SLOTS);
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);

    // Field widths
    localparam int KIND_W = 2;
    localparam int PC_W   = 64;
    localparam int QID_W  = 16;
    localparam int DIDX_W = 16;
    localparam int SLOT_W = 18;
    localparam int CNT_W  = 8;
    localparam int HASH_W = 64;
    localparam int MUL_W  = 32;
    localparam int TAG_W  = 8;

    // Finalizer constants
    localparam logic [HASH_W-1:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
    localparam logic [HASH_W-1:0] MIX_MUL2 = 64'h94d049bb133111eb;
    localparam int                MIX_SH0  = 30;
    localparam int                MIX_SH1  = 27;
    localparam int                MIX_SH2  = 31;

    // Direction tags for request items
    localparam logic [TAG_W-1:0] TAG_OUT = 8'h13;
    localparam logic [TAG_W-1:0] TAG_IN  = 8'h9e;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd3;

    // Hash unit request: seed is mixed first, then each later operand is
    // folded in by xor and mixed again (two passes, or three for requests).
    typedef struct packed {
        logic              start;
        logic              three_pass;
        logic [HASH_W-1:0] seed;
        logic [HASH_W-1:0] mix_b;
        logic [HASH_W-1:0] mix_c;
    } hash_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] value;
    } hash_rsp_t;

endpackage

// ===== src/ecm_if.sv =====
// ============================================================================
// ecm_if - channel interfaces of the edge coverage counter map
// Event channel into the block and result channel out of it.
// ============================================================================
interface ecm_in_if import ecm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [PC_W-1:0]     prev_pc;
    logic [PC_W-1:0]     new_pc;
    logic [QID_W-1:0]    queue_num;
    logic [DIDX_W-1:0]   desc_index;
    logic                is_out;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    write_value;

    modport source (
        output valid, kind, prev_pc, new_pc, queue_num, desc_index, is_out, slot,
               write_value,
        input  ready
    );
    modport sink (
        input  valid, kind, prev_pc, new_pc, queue_num, desc_index, is_out, slot,
               write_value,
        output ready
    );
endinterface

interface ecm_out_if import ecm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot_used;
    logic [CNT_W-1:0]    count;
    logic [HASH_W-1:0]   mixed_hash;

    modport source (
        output valid, slot_used, count, mixed_hash,
        input  ready
    );
    modport sink (
        input  valid, slot_used, count, mixed_hash,
        output ready
    );
endinterface

// ===== src/edge_coverage_counter_map.sv =====
// ============================================================================
// edge_coverage_counter_map - 8-bit hit counter store for fuzzing coverage
// Hashes edge and request events to a counter slot and bumps it; read and
// write items inspect or overwrite a single counter.
// ============================================================================
//
//  Channel | Modport | Payload                                          | Transfer
//  --------+---------+--------------------------------------------------+----------------
//  evt     | sink    | kind prev_pc new_pc queue_num desc_index is_out  | valid && ready
//          |         | slot write_value                                 |
//  rsp     | source  | slot_used count mixed_hash                       | valid && ready
//
//  One item is in work at a time. Edge and request items go through the
//  hash unit first (two finalizer passes for an edge, three for a request,
//  on the shared 32x32 multiplier); every item then takes the counter
//  RAM read, then write-back. After reset a clearing pass writes zero to
//  all 131328 counters, one per cycle, with evt.ready low. A full result
//  register holds the item in the write-back step, and evt.ready stays low
//  until the result register takes it.
//
module edge_coverage_counter_map import ecm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ecm_in_if.sink      evt,
    ecm_out_if.source   rsp
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_HASH   = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              out_valid_reg, out_valid_next;

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  wval_reg, wval_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;
    logic [HASH_W-1:0] out_hash_reg, out_hash_next;

    hash_req_t         hreq;
    hash_rsp_t         hrsp;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [CNT_W-1:0]  ram_rdata;

    logic              out_free;
    logic              in_range;
    logic [CNT_W-1:0]  new_count;

    ecm_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .rsp   (hrsp)
    );

    ecm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TOTAL_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Compute the counter value after this item
    always_comb
    begin
        out_free = !out_valid_reg || rsp.ready;
        in_range = (slot_reg < SLOT_W'(TOTAL_SLOTS));
        unique case (kind_reg)
            KIND_EDGE, KIND_REQ: new_count = ram_rdata + CNT_W'(1);
            KIND_READ:           new_count = ram_rdata;
            default:             new_count = wval_reg;
        endcase
    end

    // Sequence clear, hash, read and write-back
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        wval_next      = wval_reg;
        hash_next      = hash_reg;
        out_slot_next  = out_slot_reg;
        out_count_next = out_count_reg;
        out_hash_next  = out_hash_reg;
        hreq           = '0;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg[ADDR_W-1:0];
        ram_wdata      = new_count;
        ram_re         = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(TOTAL_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    kind_next = evt.kind;
                    wval_next = evt.write_value;
                    hash_next = '0;
                    slot_next = evt.slot;
                    if (evt.kind == KIND_EDGE || evt.kind == KIND_REQ)
                    begin
                        hreq.start      = 1'b1;
                        hreq.three_pass = (evt.kind == KIND_REQ);
                        hreq.seed       = (evt.kind == KIND_EDGE) ? evt.prev_pc
                                                                  : HASH_W'(evt.queue_num);
                        hreq.mix_b      = (evt.kind == KIND_EDGE) ? evt.new_pc
                                                                  : HASH_W'(evt.desc_index);
                        hreq.mix_c      = HASH_W'(evt.is_out ? TAG_OUT : TAG_IN);
                        state_next      = ST_HASH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_HASH:
            begin
                if (hrsp.done)
                begin
                    hash_next = hrsp.value;
                    if (kind_reg == KIND_EDGE)
                    begin
                        slot_next = SLOT_W'(hrsp.value[EDGE_AW-1:0]);
                    end
                    else
                    begin
                        slot_next = SLOT_W'(EDGE_SLOTS) + SLOT_W'(hrsp.value[REQ_AW-1:0]);
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // Hold until the result register is free
                if (out_free)
                begin
                    ram_we         = in_range && (kind_reg != KIND_READ);
                    out_valid_next = 1'b1;
                    out_slot_next  = slot_reg;
                    out_count_next = in_range ? new_count : '0;
                    out_hash_next  = hash_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        slot_reg      <= slot_next;
        wval_reg      <= wval_next;
        hash_reg      <= hash_next;
        out_slot_reg  <= out_slot_next;
        out_count_reg <= out_count_next;
        out_hash_reg  <= out_hash_next;
    end

    assign evt.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.slot_used  = out_slot_reg;
    assign rsp.count      = out_count_reg;
    assign rsp.mixed_hash = out_hash_reg;

endmodule

// ===== src/ecm_ram.sv =====
// ============================================================================
// ecm_ram - generic simple dual port RAM
// One write port and one read port, read data registered.
// ============================================================================
module ecm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/ecm_hash.sv =====
// ============================================================================
// ecm_hash - iterative splitmix64 finalizer chain
// One 32x32 multiplier builds each 64-bit product from three partial
// products; a pass is two multiplies, items take two or three passes.
// ============================================================================
module ecm_hash import ecm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  hash_req_t req,
    output hash_rsp_t rsp
);

    // Phase of one 64-bit multiply
    localparam logic [1:0] PH_LL  = 2'd0;
    localparam logic [1:0] PH_HL  = 2'd1;
    localparam logic [1:0] PH_LH  = 2'd2;
    localparam logic [1:0] PH_SUM = 2'd3;

    localparam logic [1:0] PASS_FIRST = 2'd0;
    localparam logic [1:0] PASS_EDGE  = 2'd1;
    localparam logic [1:0] PASS_REQ   = 2'd2;

    logic              busy_reg, busy_next;
    logic [1:0]        phase_reg, phase_next;
    logic              round_reg, round_next;
    logic [1:0]        pass_reg, pass_next;
    logic              three_reg, three_next;
    logic              done_reg, done_next;
    logic [HASH_W-1:0] h_reg, h_next;
    logic [HASH_W-1:0] prod_reg, prod_next;
    logic [HASH_W-1:0] acc_reg, acc_next;
    logic [HASH_W-1:0] opb_reg, opb_next;
    logic [HASH_W-1:0] opc_reg, opc_next;
    logic [HASH_W-1:0] value_reg, value_next;

    logic [HASH_W-1:0]  mul_c;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic [HASH_W-1:0]  sum;
    logic [HASH_W-1:0]  fin1;
    logic [HASH_W-1:0]  fin2;
    logic [HASH_W-1:0]  nxt_op;
    logic               last_pass;

    // Pick the partial product for this phase
    always_comb
    begin
        mul_c = round_reg ? MIX_MUL2 : MIX_MUL1;
        unique case (phase_reg)
            PH_LL:
            begin
                mul_a = h_reg[MUL_W-1:0];
                mul_b = mul_c[MUL_W-1:0];
            end
            PH_HL:
            begin
                mul_a = h_reg[HASH_W-1:MUL_W];
                mul_b = mul_c[MUL_W-1:0];
            end
            PH_LH:
            begin
                mul_a = h_reg[MUL_W-1:0];
                mul_b = mul_c[HASH_W-1:MUL_W];
            end
            default:
            begin
                mul_a = h_reg[MUL_W-1:0];
                mul_b = mul_c[MUL_W-1:0];
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Final add of the product and the xor-shift that follows it
    always_comb
    begin
        sum       = acc_reg + {prod_reg[MUL_W-1:0], {MUL_W{1'b0}}};
        fin1      = sum ^ (sum >> MIX_SH1);
        fin2      = sum ^ (sum >> MIX_SH2);
        nxt_op    = fin2 ^ ((pass_reg == PASS_FIRST) ? opb_reg : opc_reg);
        last_pass = (pass_reg == (three_reg ? PASS_REQ : PASS_EDGE));
    end

    // Sequence passes, rounds and phases
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        round_next = round_reg;
        pass_next  = pass_reg;
        three_next = three_reg;
        done_next  = 1'b0;
        h_next     = h_reg;
        prod_next  = mul_p;
        acc_next   = acc_reg;
        opb_next   = opb_reg;
        opc_next   = opc_reg;
        value_next = value_reg;

        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next  = 1'b1;
                phase_next = PH_LL;
                round_next = 1'b0;
                pass_next  = PASS_FIRST;
                three_next = req.three_pass;
                h_next     = req.seed ^ (req.seed >> MIX_SH0);
                opb_next   = req.mix_b;
                opc_next   = req.mix_c;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_LL:
                begin
                    phase_next = PH_HL;
                end
                PH_HL:
                begin
                    acc_next   = prod_reg;
                    phase_next = PH_LH;
                end
                PH_LH:
                begin
                    acc_next   = sum;
                    phase_next = PH_SUM;
                end
                default:
                begin
                    phase_next = PH_LL;
                    if (!round_reg)
                    begin
                        h_next     = fin1;
                        round_next = 1'b1;
                    end
                    else if (last_pass)
                    begin
                        value_next = fin2;
                        done_next  = 1'b1;
                        busy_next  = 1'b0;
                    end
                    else
                    begin
                        h_next     = nxt_op ^ (nxt_op >> MIX_SH0);
                        round_next = 1'b0;
                        pass_next  = pass_reg + 2'd1;
                    end
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_LL;
            round_reg <= 1'b0;
            pass_reg  <= PASS_FIRST;
            three_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            round_reg <= round_next;
            pass_reg  <= pass_next;
            three_reg <= three_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        h_reg     <= h_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        opb_reg   <= opb_next;
        opc_reg   <= opc_next;
        value_reg <= value_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

// ===== bench/counter_map_checker.sv =====
// ============================================================================
// counter_map_checker - result checker for the edge coverage counter map
// Watches the event and result channels, predicts each result from its own
// copy of the counter store and compares the results field by field.
// ============================================================================
module counter_map_checker import ecm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    ecm_in_if    evt,
    ecm_out_if   rsp,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_used;
        logic [CNT_W-1:0]  count;
        logic [HASH_W-1:0] mixed_hash;
    } tally_t;

    logic [CNT_W-1:0] hit_counters [TOTAL_SLOTS];
    tally_t           expected_tally_q [$];
    int               mismatch_cnt;

    // splitmix64 finalizer
    function automatic logic [HASH_W-1:0] finalize(input logic [HASH_W-1:0] h);
        h = h ^ (h >> MIX_SH0);
        h = h * MIX_MUL1;
        h = h ^ (h >> MIX_SH1);
        h = h * MIX_MUL2;
        h = h ^ (h >> MIX_SH2);
        return h;
    endfunction

    // Apply one event to the counter copy and return the result it causes
    function automatic tally_t count_event();
        tally_t            t;
        logic [HASH_W-1:0] h;
        t = '0;
        case (evt.kind)
            KIND_EDGE:
            begin
                h = finalize(finalize(evt.prev_pc) ^ evt.new_pc);
                t.slot_used = SLOT_W'(h % HASH_W'(EDGE_SLOTS));
                hit_counters[t.slot_used] = hit_counters[t.slot_used] + 1'b1;
                t.count = hit_counters[t.slot_used];
                t.mixed_hash = h;
            end
            KIND_REQ:
            begin
                h = finalize(HASH_W'(evt.queue_num));
                h = finalize(h ^ HASH_W'(evt.desc_index));
                h = finalize(h ^ HASH_W'(evt.is_out ? TAG_OUT : TAG_IN));
                t.slot_used = SLOT_W'(EDGE_SLOTS) + SLOT_W'(h % HASH_W'(REQ_SLOTS));
                hit_counters[t.slot_used] = hit_counters[t.slot_used] + 1'b1;
                t.count = hit_counters[t.slot_used];
                t.mixed_hash = h;
            end
            default:
            begin
                // read or write; an out-of-range slot touches nothing
                t.slot_used = evt.slot;
                if (int'(evt.slot) < TOTAL_SLOTS)
                begin
                    if (evt.kind == KIND_WRITE)
                        hit_counters[evt.slot] = evt.write_value;
                    t.count = hit_counters[evt.slot];
                end
            end
        endcase
        return t;
    endfunction

    task automatic report_mismatch(input string what, input tally_t want, input tally_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s: expected slot %0d count %0d hash %h, got slot %0d count %0d hash %h",
                     $realtime, what, want.slot_used, want.count, want.mixed_hash,
                     got.slot_used, got.count, got.mixed_hash);
    endtask

    // Compare result transfers, then predict event transfers
    always @(posedge clk or negedge rst_n)
    begin
        tally_t got;
        tally_t want;
        if (!rst_n)
        begin
            expected_tally_q.delete();
            foreach (hit_counters[i])
                hit_counters[i] = '0;
            mismatch_cnt = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.slot_used, rsp.count, rsp.mixed_hash};
                if (expected_tally_q.size() == 0)
                    report_mismatch("result with none expected", '0, got);
                else
                begin
                    want = expected_tally_q.pop_front();
                    if (got.slot_used !== want.slot_used || got.count !== want.count ||
                        got.mixed_hash !== want.mixed_hash)
                        report_mismatch("result mismatch", want, got);
                end
            end
            if (evt.valid && evt.ready)
                expected_tally_q.insert(expected_tally_q.size(), count_event());
            errors  <= mismatch_cnt;
            pending <= expected_tally_q.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// ============================================================================
// tb - testbench top for the edge coverage counter map
// Drives directed and random events with random idling on both channels,
// a long result hold-off, and a verdict from the checker's counts.
// ============================================================================
module tb import ecm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // No-transfer cycles allowed; covers the clearing pass after reset
    localparam int STALL_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1680;
    localparam int PHASE_LEN    = 560;
    localparam int HOLD_OFF     = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [PC_W-1:0]   prev_pc;
        logic [PC_W-1:0]   new_pc;
        logic [QID_W-1:0]  queue_num;
        logic [DIDX_W-1:0] desc_index;
        logic              is_out;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  write_value;
    } event_item_t;

    logic clk;
    logic rst_n;
    int   chk_errors;
    int   chk_pending;
    int   idle_phase;
    int   stall_cycles;

    logic [PC_W-1:0]   hot_prev [3];
    logic [PC_W-1:0]   hot_new [3];
    logic [QID_W-1:0]  hot_qid [2];
    logic [DIDX_W-1:0] hot_didx [2];
    logic              hot_dir [2];

    ecm_in_if  evt_ch ();
    ecm_out_if rsp_ch ();

    edge_coverage_counter_map u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .rsp   (rsp_ch)
    );

    counter_map_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_ch),
        .rsp     (rsp_ch),
        .errors  (chk_errors),
        .pending (chk_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [PC_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Item of the given kind with every field random
    function automatic event_item_t blank_item(input logic [KIND_W-1:0] k);
        event_item_t it;
        it.kind        = k;
        it.prev_pc     = rand64();
        it.new_pc      = rand64();
        it.queue_num   = QID_W'($urandom);
        it.desc_index  = DIDX_W'($urandom);
        it.is_out      = 1'($urandom);
        it.slot        = SLOT_W'($urandom);
        it.write_value = CNT_W'($urandom);
        return it;
    endfunction

    // Mostly edges and requests, many of them hot so counters wrap; reads and writes
    // cover both regions and slots beyond the store
    function automatic event_item_t random_item();
        event_item_t it;
        int          pick;
        int          h;
        pick = $urandom_range(0, 99);
        if (pick < 28)
        begin
            it = blank_item(KIND_EDGE);
            h = (pick < 22) ? 0 : $urandom_range(1, 2);
            it.prev_pc = hot_prev[h];
            it.new_pc  = hot_new[h];
        end
        else if (pick < 48)
            it = blank_item(KIND_EDGE);
        else if (pick < 58)
        begin
            it = blank_item(KIND_REQ);
            h = $urandom_range(0, 1);
            it.queue_num  = hot_qid[h];
            it.desc_index = hot_didx[h];
            it.is_out     = hot_dir[h];
        end
        else if (pick < 70)
        begin
            it = blank_item(KIND_REQ);
            if ($urandom_range(0, 1))
                it.queue_num = QID_W'($urandom_range(0, 7));
        end
        else if (pick < 80)
        begin
            it = blank_item(KIND_READ);
            case ($urandom_range(0, 2))
                0: it.slot = SLOT_W'($urandom_range(0, TOTAL_SLOTS - 1));
                1: it.slot = SLOT_W'(EDGE_SLOTS + $urandom_range(0, REQ_SLOTS - 1));
                default: ;
            endcase
        end
        else if (pick < 92)
        begin
            it = blank_item(KIND_WRITE);
            if ($urandom_range(0, 3) != 0)
            begin
                it.slot = SLOT_W'(EDGE_SLOTS + $urandom_range(0, REQ_SLOTS - 1));
                it.write_value = CNT_W'($urandom_range(250, 255));
            end
        end
        else
        begin
            it = blank_item($urandom_range(0, 1) ? KIND_READ : KIND_WRITE);
            it.slot = SLOT_W'($urandom_range(TOTAL_SLOTS, (1 << SLOT_W) - 1));
        end
        return it;
    endfunction

    // Offer one item after random gaps and hold it until the transfer
    task automatic send_item(input event_item_t it);
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 38 : (idle_phase == 1) ? 46 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        evt_ch.valid       <= 1'b1;
        evt_ch.kind        <= it.kind;
        evt_ch.prev_pc     <= it.prev_pc;
        evt_ch.new_pc      <= it.new_pc;
        evt_ch.queue_num   <= it.queue_num;
        evt_ch.desc_index  <= it.desc_index;
        evt_ch.is_out      <= it.is_out;
        evt_ch.slot        <= it.slot;
        evt_ch.write_value <= it.write_value;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        event_item_t it;
        idle_phase = 0;
        rst_n                <= 1'b0;
        evt_ch.valid         <= 1'b0;
        evt_ch.kind          <= KIND_EDGE;
        evt_ch.prev_pc       <= '0;
        evt_ch.new_pc        <= '0;
        evt_ch.queue_num     <= '0;
        evt_ch.desc_index    <= '0;
        evt_ch.is_out        <= 1'b0;
        evt_ch.slot          <= '0;
        evt_ch.write_value   <= '0;
        foreach (hot_prev[i])
        begin
            hot_prev[i] = rand64();
            hot_new[i]  = rand64();
        end
        foreach (hot_qid[i])
        begin
            hot_qid[i]  = QID_W'($urandom);
            hot_didx[i] = DIDX_W'($urandom);
            hot_dir[i]  = 1'(i);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Edges at the extremes of both addresses
        it = blank_item(KIND_EDGE);
        it.prev_pc = '0;
        it.new_pc  = '0;
        send_item(it);
        send_item(it);
        it.prev_pc = '1;
        it.new_pc  = '1;
        send_item(it);
        it.prev_pc = {(PC_W/2){2'b01}};
        it.new_pc  = {(PC_W/2){2'b10}};
        send_item(it);

        // Requests at the extremes, both directions
        it = blank_item(KIND_REQ);
        it.queue_num  = '0;
        it.desc_index = '0;
        it.is_out     = 1'b0;
        send_item(it);
        it.queue_num  = '1;
        it.desc_index = '1;
        it.is_out     = 1'b1;
        send_item(it);
        it.queue_num  = '0;
        it.desc_index = '1;
        send_item(it);
        it.queue_num  = '1;
        it.desc_index = '0;
        it.is_out     = 1'b0;
        send_item(it);

        // Read and write at both ends of the store and past it
        it = blank_item(KIND_READ);
        it.slot = '0;
        send_item(it);
        it = blank_item(KIND_WRITE);
        it.slot = '0;
        it.write_value = '1;
        send_item(it);
        it = blank_item(KIND_READ);
        it.slot = '0;
        send_item(it);
        it = blank_item(KIND_WRITE);
        it.slot = SLOT_W'(TOTAL_SLOTS - 1);
        it.write_value = 8'h80;
        send_item(it);
        it = blank_item(KIND_READ);
        it.slot = SLOT_W'(TOTAL_SLOTS - 1);
        send_item(it);
        it.slot = SLOT_W'(EDGE_SLOTS);
        send_item(it);
        it.slot = SLOT_W'(EDGE_SLOTS - 1);
        send_item(it);
        it = blank_item(KIND_WRITE);
        it.slot = SLOT_W'(TOTAL_SLOTS);
        it.write_value = 8'haa;
        send_item(it);
        it = blank_item(KIND_READ);
        it.slot = SLOT_W'(TOTAL_SLOTS);
        send_item(it);
        it.slot = '1;
        send_item(it);
        it = blank_item(KIND_WRITE);
        it.slot = '1;
        it.write_value = '1;
        send_item(it);
        it.slot = '0;
        it.write_value = '0;
        send_item(it);

        // Random traffic in three idling phases
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_phase = (n < PHASE_LEN) ? 0 : (n < 2 * PHASE_LEN) ? 1 : 2;
            send_item(random_item());
        end
        evt_ch.valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (chk_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk_errors == 0 && chk_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result side: random stalls, one long hold-off once phase two starts
    initial
    begin
        bit held_off;
        int stall_pct;
        held_off = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_phase == 2 && !held_off)
            begin
                held_off = 1'b1;
                repeat (HOLD_OFF)
                begin
                    rsp_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            stall_pct = (idle_phase == 0) ? 46 : (idle_phase == 1) ? 38 : 0;
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: end the run after too long without any transfer
    initial
    begin
        stall_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((evt_ch.valid && evt_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
src/ecm_pkg.sv
src/ecm_if.sv
src/ecm_ram.sv
src/ecm_hash.sv
src/edge_coverage_counter_map.sv
bench/counter_map_checker.sv
bench/tb.sv
